### hdl/olid_pkg.sv
// shared types, codes and widths of the ordered list block
package olid_pkg;

  // default list capacity
  localparam int CAPACITY_DEF = 128;

  // fixed field widths
  localparam int OP_W    = 2;
  localparam int POS_W   = 8;
  localparam int ITEM_W  = 64;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_GET    = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // capture request and decide its status
    logic idx_count;   // index from current length
    logic idx_pos;     // index from request position
    logic idx_inc;
    logic idx_dec;
    logic rd_en;       // memory read
    logic rd_up;       // read at index + 1 (else index - 1)
    logic rd_pos;      // read at request position
    logic wr_shift;    // write read data at index
    logic wr_item;     // write request item at position
    logic cnt_inc;
    logic cnt_dec;
    logic out_load;    // load the result register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ok;       // request passed its checks
    logic            at_pos;   // index equals position
    logic            del_end;  // index + 1 reaches length
    logic            out_busy; // result register still held
  } sts_t;

endpackage

### hdl/olid_ctrl.sv
// controller state machine of the ordered list block
module olid_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  olid_pkg::sts_t sts,
  output olid_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CHECK    = 3'd1;
  localparam logic [2:0] S_INS_TEST = 3'd2;
  localparam logic [2:0] S_INS_WR   = 3'd3;
  localparam logic [2:0] S_DEL_TEST = 3'd4;
  localparam logic [2:0] S_DEL_WR   = 3'd5;
  localparam logic [2:0] S_GET_WAIT = 3'd6;
  localparam logic [2:0] S_FINISH   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.ok) begin
          state_nxt = S_FINISH;
        end else begin
          case (sts.op)
            olid_pkg::OP_INSERT: begin
              cmd.idx_count = 1'b1;
              state_nxt     = S_INS_TEST;
            end
            olid_pkg::OP_DELETE: begin
              cmd.idx_pos = 1'b1;
              state_nxt   = S_DEL_TEST;
            end
            olid_pkg::OP_GET: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_pos = 1'b1;
              state_nxt  = S_GET_WAIT;
            end
            default: begin
              state_nxt = S_FINISH;
            end
          endcase
        end
      end
      // shift entries up from the tail, then drop the item in
      S_INS_TEST: begin
        if (sts.at_pos) begin
          cmd.wr_item = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_FINISH;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_dec  = 1'b1;
        state_nxt    = S_INS_TEST;
      end
      // shift entries down toward the removed slot
      S_DEL_TEST: begin
        if (sts.del_end) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_FINISH;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_up = 1'b1;
          state_nxt = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = S_DEL_TEST;
      end
      S_GET_WAIT: begin
        state_nxt = S_FINISH;
      end
      // hand the result over once the output register is free
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/olid_dp.sv
// datapath of the ordered list block: entry memory, length, index and result
module olid_dp #(
  parameter int CAPACITY = olid_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  olid_pkg::cmd_t               cmd,
  output olid_pkg::sts_t               sts,
  input  logic [olid_pkg::OP_W-1:0]    in_op,
  input  logic [olid_pkg::POS_W-1:0]   in_position,
  input  logic [olid_pkg::ITEM_W-1:0]  in_item_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [olid_pkg::STAT_W-1:0]  out_status,
  output logic [olid_pkg::ITEM_W-1:0]  out_item_out,
  output logic [olid_pkg::COUNT_W-1:0] out_count_out
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > olid_pkg::POS_W) ? CW : olid_pkg::POS_W) + 1;

  logic [olid_pkg::ITEM_W-1:0]  mem [CAPACITY];
  logic [olid_pkg::ITEM_W-1:0]  rd_r;
  logic [olid_pkg::OP_W-1:0]    op_r;
  logic [olid_pkg::POS_W-1:0]   pos_r;
  logic [olid_pkg::ITEM_W-1:0]  item_r;
  logic [olid_pkg::STAT_W-1:0]  status_r;
  logic [olid_pkg::STAT_W-1:0]  status_nxt;
  logic [CW-1:0]                count_r;
  logic [AW-1:0]                idx_r;
  logic                         out_valid_r;
  logic [olid_pkg::STAT_W-1:0]  out_status_r;
  logic [olid_pkg::ITEM_W-1:0]  out_item_r;
  logic [olid_pkg::COUNT_W-1:0] out_count_r;

  logic [XW-1:0] pos_in_x;
  logic [XW-1:0] count_x;
  logic [AW-1:0] pos_a;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [olid_pkg::ITEM_W-1:0] wr_data;
  logic          wr_en;

  assign pos_in_x = XW'(in_position);
  assign count_x  = XW'(count_r);
  assign pos_a    = AW'(pos_r);

  // range and capacity checks on the incoming request
  always_comb begin
    case (in_op)
      olid_pkg::OP_INSERT: begin
        if (pos_in_x > count_x) begin
          status_nxt = olid_pkg::ST_RANGE;
        end else if (count_x >= XW'(CAPACITY)) begin
          status_nxt = olid_pkg::ST_FULL;
        end else begin
          status_nxt = olid_pkg::ST_OK;
        end
      end
      olid_pkg::OP_DELETE, olid_pkg::OP_GET: begin
        status_nxt = (pos_in_x >= count_x) ? olid_pkg::ST_RANGE : olid_pkg::ST_OK;
      end
      default: begin
        status_nxt = olid_pkg::ST_RANGE;
      end
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      pos_r    <= in_position;
      item_r   <= in_item_in;
      status_r <= status_nxt;
    end
  end

  // memory addressing
  always_comb begin
    if (cmd.rd_pos) begin
      rd_addr = pos_a;
    end else if (cmd.rd_up) begin
      rd_addr = idx_r + AW'(1);
    end else begin
      rd_addr = idx_r - AW'(1);
    end
  end

  assign wr_en   = cmd.wr_shift | cmd.wr_item;
  assign wr_addr = cmd.wr_item ? pos_a : idx_r;
  assign wr_data = cmd.wr_item ? item_r : rd_r;

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  // shift index
  always_ff @(posedge clk) begin
    if (cmd.idx_count) begin
      idx_r <= AW'(count_r);
    end else if (cmd.idx_pos) begin
      idx_r <= pos_a;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + AW'(1);
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - AW'(1);
    end
  end

  // list length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.cnt_inc) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_r <= count_r - CW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_item_r   <= (op_r == olid_pkg::OP_GET && status_r == olid_pkg::ST_OK) ?
                      rd_r : '0;
      out_count_r  <= olid_pkg::COUNT_W'(count_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_item_out  = out_item_r;
  assign out_count_out = out_count_r;

  // status to controller
  assign sts.op       = op_r;
  assign sts.ok       = (status_r == olid_pkg::ST_OK);
  assign sts.at_pos   = (XW'(idx_r) == XW'(pos_r));
  assign sts.del_end  = ((XW'(idx_r) + XW'(1)) >= count_x);
  assign sts.out_busy = out_valid_r & ~out_ready;

endmodule

### hdl/ordered_list_insert_delete.sv
// top level of the ordered list block: controller, datapath and checks
// Ordered list of 64-bit items held in a single-port-style memory of CAPACITY
// entries, one request at a time. A get is captured, checked, read at its
// position and handed over. An insert at position p into a list of length n
// shifts n-p entries and a delete at p shifts n-p-1 entries; every
// shifted entry costs one memory read and one memory write on the entry
// memory's single read port. Rejected requests (bad position, full list,
// unknown operation) go from the check straight to the result and leave
// the list unchanged. Each request waits to hand over its result while the
// previous result is still held on a stalled output. The next request is
// taken once the previous result sits in the output register.
module ordered_list_insert_delete #(
  parameter int CAPACITY = olid_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [olid_pkg::OP_W-1:0]    in_op,
  input  logic [olid_pkg::POS_W-1:0]   in_position,
  input  logic [olid_pkg::ITEM_W-1:0]  in_item_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [olid_pkg::STAT_W-1:0]  out_status,
  output logic [olid_pkg::ITEM_W-1:0]  out_item_out,
  output logic [olid_pkg::COUNT_W-1:0] out_count_out
);

  olid_pkg::cmd_t cmd;
  olid_pkg::sts_t sts;

  // controller
  olid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  olid_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_op         (in_op),
    .in_position   (in_position),
    .in_item_in    (in_item_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_item_out  (out_item_out),
    .out_count_out (out_count_out)
  );

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in flight");

  // shift write and item write never collide
  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_shift && cmd.wr_item))
    else $error("two memory writes in one cycle");

  // length changes only for requests that passed their checks
  a_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt_inc || cmd.cnt_dec) |-> sts.ok)
    else $error("length changed by a rejected request");

  // a loaded result shows up on the output
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("result loaded but not presented");

endmodule
